// ===== hdl/bacc_pkg.sv =====
// ----------------------------------------------------------------------------
// BCD alarm clock package
// Shared types, digit limits and the load clamp helper for the alarm clock
// with countdown.
// ----------------------------------------------------------------------------
`default_nettype none

package bacc_pkg;

    // Number of digit positions in the time, alarm and countdown registers
    localparam int NUM_DIGITS = 4;

    // Digit limits
    localparam logic [3:0] DIGIT_MAX       = 4'd9;
    localparam logic [3:0] TENS_MAX        = 4'd5;
    localparam logic [3:0] HOUR_TENS_MAX   = 4'd2;
    localparam logic [3:0] LATE_HOUR_MAX   = 4'd3;

    // Request kinds carried on s_tuser
    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_SET_TIME  = 3'd1,
        ACT_SET_ALARM = 3'd2,
        ACT_SET_COUNT = 3'd3,
        ACT_STOP      = 3'd4
    } action_t;

    // Per-request controls shared by every digit cell
    typedef struct packed {
        logic load_time;
        logic load_alarm;
        logic load_cnt;
        logic cnt_step;
    } cell_ctl_t;

    // One result, first field in the highest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       countdown_expired;
        logic       alarm_ringing;
        logic [3:0] count_d0;
        logic [2:0] count_d1;
        logic [3:0] count_d2;
        logic [3:0] count_d3;
        logic [3:0] minute_units;
        logic [2:0] minute_tens;
        logic [3:0] hour_units;
        logic [1:0] hour_tens;
    } result_t;

    // Saturate a digit at its limit
    function automatic logic [3:0] sat_digit(input logic [3:0] v, input logic [3:0] top);
        return (v > top) ? top : v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bcd_alarm_clock_countdown_top.sv =====
// ----------------------------------------------------------------------------
// A result is registered in the output register, or in the skid register while an earlier result waits.
// Throughput: one request per cycle while the skid slot is empty; the carry and
// borrow ripple through the four digit cells within that cycle.
// Two result slots let one request be taken while a result waits downstream.
// Reset (rst_n low, asynchronous) sets the clock to 00:00, clears the alarm,
// countdown and both flags, and empties the result buffer.
// ----------------------------------------------------------------------------
// BCD alarm clock with countdown, top level
// Chain of four digit cells holding clock, alarm and countdown digits, with
// the alarm and countdown flags and a stream result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_alarm_clock_countdown_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // load_d3, load_d2, load_d1, load_d0
    input  wire logic [2:0]  s_tuser,  // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // hour_tens, hour_units, minute_tens,
                                       // minute_units, count_d3, count_d2,
                                       // count_d1, count_d0, alarm_ringing,
                                       // countdown_expired, zero pad
);
    import bacc_pkg::*;

    logic       accept;
    action_t    action;
    logic       is_tick, is_stop;
    cell_ctl_t  ctl;
    logic [3:0] load_d [NUM_DIGITS];
    logic [3:0] tload  [NUM_DIGITS];
    logic [3:0] cload  [NUM_DIGITS];
    logic [3:0] time_top [NUM_DIGITS];
    logic [3:0] cnt_top  [NUM_DIGITS];
    logic [3:0] time_q   [NUM_DIGITS];
    logic [3:0] time_nx  [NUM_DIGITS];
    logic [3:0] cnt_q    [NUM_DIGITS];
    logic [3:0] cnt_nx   [NUM_DIGITS];
    logic [NUM_DIGITS-1:0] match;
    logic [NUM_DIGITS-1:0] cnt_zero;
    logic [NUM_DIGITS-1:0] cnt_next_zero;
    logic [NUM_DIGITS:0]   carry;
    logic [NUM_DIGITS:0]   borrow;
    logic       expire;
    logic       armed_reg, armed_next;
    logic       ring_reg, ring_next;
    logic       running_reg, running_next;
    logic       expired_reg, expired_next;
    result_t    result;
    result_t    out_data;

    // Decode the request
    assign accept  = s_tvalid && s_tready;
    assign action  = action_t'(s_tuser);
    assign is_tick = accept && (action == ACT_TICK);
    assign is_stop = accept && (action == ACT_STOP);

    assign load_d[3] = s_tdata[3:0];
    assign load_d[2] = s_tdata[7:4];
    assign load_d[1] = s_tdata[11:8];
    assign load_d[0] = s_tdata[15:12];

    // Clamp load digits: HH:MM for time and alarm, 9,9,5,9 for countdown
    assign tload[3] = sat_digit(load_d[3], HOUR_TENS_MAX);
    assign tload[2] = sat_digit(load_d[2],
                                (tload[3] == HOUR_TENS_MAX) ? LATE_HOUR_MAX : DIGIT_MAX);
    assign tload[1] = sat_digit(load_d[1], TENS_MAX);
    assign tload[0] = sat_digit(load_d[0], DIGIT_MAX);
    assign cload[3] = sat_digit(load_d[3], DIGIT_MAX);
    assign cload[2] = sat_digit(load_d[2], DIGIT_MAX);
    assign cload[1] = sat_digit(load_d[1], TENS_MAX);
    assign cload[0] = sat_digit(load_d[0], DIGIT_MAX);

    // Per-digit wrap limits; hour units stop at 3 in the twenties
    assign time_top[3] = HOUR_TENS_MAX;
    assign time_top[2] = (time_q[3] == HOUR_TENS_MAX) ? LATE_HOUR_MAX : DIGIT_MAX;
    assign time_top[1] = TENS_MAX;
    assign time_top[0] = DIGIT_MAX;
    assign cnt_top[3]  = DIGIT_MAX;
    assign cnt_top[2]  = DIGIT_MAX;
    assign cnt_top[1]  = TENS_MAX;
    assign cnt_top[0]  = DIGIT_MAX;

    // Cell controls; a countdown at zero does not step
    always_comb
    begin
        ctl.load_time  = accept && (action == ACT_SET_TIME);
        ctl.load_alarm = accept && (action == ACT_SET_ALARM);
        ctl.load_cnt   = accept && (action == ACT_SET_COUNT);
        ctl.cnt_step   = is_tick && running_reg && !(&cnt_zero);
    end

    assign carry[0]  = is_tick;
    assign borrow[0] = 1'b1;

    // Digit chain, least significant cell first
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        bacc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .tload       (tload[i]),
            .cload       (cload[i]),
            .time_top    (time_top[i]),
            .cnt_top     (cnt_top[i]),
            .carry_in    (carry[i]),
            .borrow_in   (borrow[i]),
            .carry_out   (carry[i+1]),
            .borrow_out  (borrow[i+1]),
            .time_q      (time_q[i]),
            .time_next_q (time_nx[i]),
            .cnt_q       (cnt_q[i]),
            .cnt_next_q  (cnt_nx[i]),
            .match       (match[i])
        );
        assign cnt_zero[i]      = (cnt_q[i] == 4'd0);
        assign cnt_next_zero[i] = (cnt_nx[i] == 4'd0);
    end

    // Update alarm and countdown flags
    assign expire = is_tick && running_reg && (&cnt_next_zero);

    always_comb
    begin
        armed_next   = armed_reg;
        running_next = running_reg;
        expired_next = expired_reg;
        if (ctl.load_alarm)
        begin
            armed_next = 1'b1;
        end
        else if (is_stop)
        begin
            armed_next = 1'b0;
        end
        if (ctl.load_cnt)
        begin
            running_next = 1'b1;
            expired_next = 1'b0;
        end
        else if (is_stop)
        begin
            expired_next = 1'b0;
        end
        else if (expire)
        begin
            running_next = 1'b0;
            expired_next = 1'b1;
        end
        ring_next = (ring_reg && !is_stop) || (armed_next && (&match));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            ring_reg    <= 1'b0;
            running_reg <= 1'b0;
            expired_reg <= 1'b0;
        end
        else if (accept)
        begin
            armed_reg   <= armed_next;
            ring_reg    <= ring_next;
            running_reg <= running_next;
            expired_reg <= expired_next;
        end
    end

    // Build the result from the state after this request
    always_comb
    begin
        result.pad               = '0;
        result.countdown_expired = expired_next;
        result.alarm_ringing     = ring_next;
        result.count_d0          = cnt_nx[0];
        result.count_d1          = cnt_nx[1][2:0];
        result.count_d2          = cnt_nx[2];
        result.count_d3          = cnt_nx[3];
        result.minute_units      = time_nx[0];
        result.minute_tens       = time_nx[1][2:0];
        result.hour_units        = time_nx[2];
        result.hour_tens         = time_nx[3][1:0];
    end

    bacc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data;

endmodule

`default_nettype wire

// ===== hdl/bacc_cell.sv =====
// ----------------------------------------------------------------------------
// BCD alarm clock digit cell
// Holds one time, alarm and countdown digit; passes the clock carry and the
// countdown borrow to the next higher cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bacc_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bacc_pkg::cell_ctl_t ctl,
    input  wire logic [3:0]         tload,
    input  wire logic [3:0]         cload,
    input  wire logic [3:0]         time_top,
    input  wire logic [3:0]         cnt_top,
    input  wire logic               carry_in,
    input  wire logic               borrow_in,
    output logic                    carry_out,
    output logic                    borrow_out,
    output logic [3:0]              time_q,
    output logic [3:0]              time_next_q,
    output logic [3:0]              cnt_q,
    output logic [3:0]              cnt_next_q,
    output logic                    match
);
    import bacc_pkg::*;

    logic [3:0] time_reg, time_next;
    logic [3:0] alarm_reg, alarm_next;
    logic [3:0] cnt_reg, cnt_next;

    // Advance the clock digit, wrapping at its limit
    always_comb
    begin
        carry_out = carry_in && (time_reg >= time_top);
        time_next = time_reg;
        if (ctl.load_time)
        begin
            time_next = tload;
        end
        else if (carry_in)
        begin
            time_next = carry_out ? 4'd0 : time_reg + 4'd1;
        end
    end

    // Load the alarm digit
    always_comb
    begin
        alarm_next = ctl.load_alarm ? tload : alarm_reg;
    end

    // Step the countdown digit, reloading on borrow
    always_comb
    begin
        borrow_out = borrow_in && (cnt_reg == 4'd0);
        cnt_next   = cnt_reg;
        if (ctl.load_cnt)
        begin
            cnt_next = cload;
        end
        else if (ctl.cnt_step && borrow_in)
        begin
            cnt_next = borrow_out ? cnt_top : cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            alarm_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            time_reg  <= time_next;
            alarm_reg <= alarm_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign time_q      = time_reg;
    assign time_next_q = time_next;
    assign cnt_q       = cnt_reg;
    assign cnt_next_q  = cnt_next;
    assign match       = (alarm_next == time_next);

endmodule

`default_nettype wire

// ===== hdl/bacc_outbuf.sv =====
// ----------------------------------------------------------------------------
// BCD alarm clock result buffer
// Two-entry output register with skid stage so a new request is taken while
// a finished result still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module bacc_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bacc_pkg::result_t push_data,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bacc_pkg::result_t      out_data
);
    import bacc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    // Move results between the skid and output registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/bacc_checker.sv =====
// ----------------------------------------------------------------------------
// BCD alarm clock port checker
// Watches the top level's stream ports for buffer and digit range slips.
// ----------------------------------------------------------------------------
`default_nettype none

module bacc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata
);

    // Hold back requests only while a result is waiting
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result pending");

    // A result is valid in the cycle after every taken request
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("no result after a taken request");

    // Clock digits stay within a 24-hour day
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[8:6] <= 3'd5)
                     && !((m_tdata[1:0] == 2'd2) && (m_tdata[5:2] > 4'd3)))
        else $error("clock digits out of range");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind bcd_alarm_clock_countdown_top bacc_checker u_bacc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/bcd_alarm_clock_countdown_checker.sv =====
// ----------------------------------------------------------------------------
// BCD alarm clock with countdown, result checker
// Watches both stream channels. Tracks clock, alarm and countdown state
// from every accepted request and compares each accepted result, field by
// field, against the oldest predicted status. Hands the mismatch count and
// the number of outstanding predictions back to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_alarm_clock_countdown_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,  // load_d3, load_d2, load_d1, load_d0
    input  wire logic [2:0]  s_tuser,  // action
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,  // hour_tens .. countdown_expired, pad
    output int               mismatch_count,
    output int               pending_results,
    output int               results_checked,
    output int               ring_results,
    output int               expiry_results
);
    import bacc_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Digit vectors hold {d3, d2, d1, d0}, most significant digit on top
    logic [15:0] clock_hhmm;
    logic [15:0] alarm_hhmm;
    logic [15:0] count_digits;
    logic        alarm_armed;
    logic        ring_latched;
    logic        count_running;
    logic        expired_latched;

    // Predicted status, oldest first
    result_t expected_status[$];

    // Clamp loaded HH:MM digits into a legal 24-hour time
    function automatic logic [15:0] clamp_hhmm(input logic [15:0] raw);
        logic [3:0] h1, h0, m1, m0;
        h1 = (raw[15:12] > HOUR_TENS_MAX) ? HOUR_TENS_MAX : raw[15:12];
        h0 = raw[11:8];
        if (h1 == HOUR_TENS_MAX && h0 > LATE_HOUR_MAX)
            h0 = LATE_HOUR_MAX;
        else if (h0 > DIGIT_MAX)
            h0 = DIGIT_MAX;
        m1 = (raw[7:4] > TENS_MAX) ? TENS_MAX : raw[7:4];
        m0 = (raw[3:0] > DIGIT_MAX) ? DIGIT_MAX : raw[3:0];
        return {h1, h0, m1, m0};
    endfunction

    // Clamp loaded countdown digits to the 9,9,5,9 weights
    function automatic logic [15:0] clamp_count(input logic [15:0] raw);
        logic [3:0] c3, c2, c1, c0;
        c3 = (raw[15:12] > DIGIT_MAX) ? DIGIT_MAX : raw[15:12];
        c2 = (raw[11:8] > DIGIT_MAX) ? DIGIT_MAX : raw[11:8];
        c1 = (raw[7:4] > TENS_MAX) ? TENS_MAX : raw[7:4];
        c0 = (raw[3:0] > DIGIT_MAX) ? DIGIT_MAX : raw[3:0];
        return {c3, c2, c1, c0};
    endfunction

    // Advance HH:MM by one minute, 23:59 wraps to 00:00
    function automatic logic [15:0] clock_plus_minute(input logic [15:0] t);
        if (t[3:0] < DIGIT_MAX)
            t[3:0] = t[3:0] + 4'd1;
        else if (t[7:4] < TENS_MAX)
            t[7:0] = {t[7:4] + 4'd1, 4'd0};
        else if ((t[15:12] < HOUR_TENS_MAX && t[11:8] < DIGIT_MAX) ||
                 (t[15:12] == HOUR_TENS_MAX && t[11:8] < LATE_HOUR_MAX))
            t[11:0] = {t[11:8] + 4'd1, 8'd0};
        else if (t[15:12] < HOUR_TENS_MAX)
            t = {t[15:12] + 4'd1, 12'd0};
        else
            t = '0;
        return t;
    endfunction

    // Step the countdown down by one; a zero count stays at zero
    function automatic logic [15:0] count_minus_one(input logic [15:0] c);
        if (c[3:0] != 4'd0)
            c[3:0] = c[3:0] - 4'd1;
        else if (c[7:4] != 4'd0)
            c[7:0] = {c[7:4] - 4'd1, DIGIT_MAX};
        else if (c[11:8] != 4'd0)
            c[11:0] = {c[11:8] - 4'd1, TENS_MAX, DIGIT_MAX};
        else if (c[15:12] != 4'd0)
            c = {c[15:12] - 4'd1, DIGIT_MAX, TENS_MAX, DIGIT_MAX};
        return c;
    endfunction

    // Apply one request to the tracked state and build the status it yields
    function automatic result_t next_status(input logic [2:0] action,
                                            input logic [15:0] loaded);
        result_t status;
        case (action)
            ACT_TICK:
            begin
                clock_hhmm = clock_plus_minute(clock_hhmm);
                if (count_running)
                begin
                    count_digits = count_minus_one(count_digits);
                    if (count_digits == '0)
                    begin
                        expired_latched = 1'b1;
                        count_running   = 1'b0;
                    end
                end
            end
            ACT_SET_TIME:
                clock_hhmm = clamp_hhmm(loaded);
            ACT_SET_ALARM:
            begin
                alarm_hhmm  = clamp_hhmm(loaded);
                alarm_armed = 1'b1;
            end
            ACT_SET_COUNT:
            begin
                count_digits    = clamp_count(loaded);
                count_running   = 1'b1;
                expired_latched = 1'b0;
            end
            ACT_STOP:
            begin
                ring_latched    = 1'b0;
                expired_latched = 1'b0;
                alarm_armed     = 1'b0;
            end
            default:
            begin
            end
        endcase

        // Latch the ring on any match of an armed alarm
        if (alarm_armed && alarm_hhmm == clock_hhmm)
            ring_latched = 1'b1;

        status                   = '0;
        status.hour_tens         = clock_hhmm[13:12];
        status.hour_units        = clock_hhmm[11:8];
        status.minute_tens       = clock_hhmm[6:4];
        status.minute_units      = clock_hhmm[3:0];
        status.count_d3          = count_digits[15:12];
        status.count_d2          = count_digits[11:8];
        status.count_d1          = count_digits[6:4];
        status.count_d0          = count_digits[3:0];
        status.alarm_ringing     = ring_latched;
        status.countdown_expired = expired_latched;
        return status;
    endfunction

    // Count a field mismatch, report only the first few
    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("MISMATCH result %0d %s: expected %0d, got %0d",
                         results_checked, field, want, got);
        end
    endtask

    // Track requests and check results
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            clock_hhmm      = '0;
            alarm_hhmm      = '0;
            count_digits    = '0;
            alarm_armed     = 1'b0;
            ring_latched    = 1'b0;
            count_running   = 1'b0;
            expired_latched = 1'b0;
            expected_status.delete();
            mismatch_count  = 0;
            results_checked = 0;
            ring_results    = 0;
            expiry_results  = 0;
            pending_results <= 0;
        end
        else
        begin
            // Check the result taken at this edge against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (expected_status.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("UNEXPECTED result with nothing pending: %h", m_tdata);
                end
                else
                begin
                    want = expected_status.pop_front();
                    compare_field("hour_tens", 32'(want.hour_tens),
                                  32'(got.hour_tens));
                    compare_field("hour_units", 32'(want.hour_units),
                                  32'(got.hour_units));
                    compare_field("minute_tens", 32'(want.minute_tens),
                                  32'(got.minute_tens));
                    compare_field("minute_units", 32'(want.minute_units),
                                  32'(got.minute_units));
                    compare_field("count_d3", 32'(want.count_d3), 32'(got.count_d3));
                    compare_field("count_d2", 32'(want.count_d2), 32'(got.count_d2));
                    compare_field("count_d1", 32'(want.count_d1), 32'(got.count_d1));
                    compare_field("count_d0", 32'(want.count_d0), 32'(got.count_d0));
                    compare_field("alarm_ringing", 32'(want.alarm_ringing),
                                  32'(got.alarm_ringing));
                    compare_field("countdown_expired", 32'(want.countdown_expired),
                                  32'(got.countdown_expired));
                    compare_field("pad", 32'(want.pad), 32'(got.pad));
                    results_checked++;
                    if (want.alarm_ringing)
                        ring_results++;
                    if (want.countdown_expired)
                        expiry_results++;
                end
            end

            // Predict the status for the request taken at this edge
            if (s_tvalid && s_tready)
                expected_status.push_back(next_status(s_tuser,
                    {s_tdata[3:0], s_tdata[7:4], s_tdata[11:8], s_tdata[15:12]}));

            pending_results <= expected_status.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/bcd_alarm_clock_countdown_top_test.sv =====
// ----------------------------------------------------------------------------
// BCD alarm clock with countdown, testbench top
// Drives directed corner requests, then randomized alarm, countdown, wrap
// and noise sequences through a bursty sender, while the result side
// stalls on shifting patterns. The checker beside the block does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_alarm_clock_countdown_top_test;
    import bacc_pkg::*;

    localparam int RANDOM_REQUESTS = 950;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ACTION_CODES    = 8;
    localparam int MINUTES_PER_DAY = 1440;

    // Result-side stall patterns
    typedef enum logic [1:0] {
        RX_READY,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SLOW
    } rx_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // load_d3, load_d2, load_d1, load_d0
    logic [2:0]  s_tuser  = '0;    // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // hour_tens .. countdown_expired, pad

    int       mismatch_count;
    int       pending_results;
    int       results_checked;
    int       ring_results;
    int       expiry_results;
    int       requests_sent = 0;
    int       burst_left    = 0;
    int       cycle_count   = 0;
    rx_mode_t rx_mode       = RX_READY;
    int       rx_phase      = 0;

    bcd_alarm_clock_countdown_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bcd_alarm_clock_countdown_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .ring_results    (ring_results),
        .expiry_results  (expiry_results)
    );

    // Clock, period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("bcd_alarm_clock_countdown_top verification failed");
            $finish;
        end
    end

    // Stall the result side, switching to a random pattern whenever the phase count runs out
    always @(posedge clk)
    begin
        if (rx_phase == 0)
        begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 3));
            rx_phase <= $urandom_range(20, 80);
        end
        else
        begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            RX_READY:    m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= (rx_phase[1:0] != 2'b00);
            default:     m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // Send one request; open a new burst after a random gap when one runs out
    task automatic send_request(input logic [2:0] act, input logic [3:0] d3,
                                input logic [3:0] d2, input logic [3:0] d1,
                                input logic [3:0] d0);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {d0, d1, d2, d3};
        do
            @(posedge clk);
        while (!s_tready);
        if (act <= ACT_STOP)
            requests_sent++;
    endtask

    task automatic tick();
        send_request(ACT_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    endtask

    // Load a time of day given in minutes after midnight
    task automatic send_minutes(input logic [2:0] act, input int mins);
        int hh, mm;
        hh = mins / 60;
        mm = mins % 60;
        send_request(act, 4'(hh / 10), 4'(hh % 10), 4'(mm / 10), 4'(mm % 10));
    endtask

    initial
    begin
        int target, lead, extra, hh, total, runs;
        int c3, c2, c1, c0;
        logic [2:0] act;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clamping, carries, wrap, alarm and countdown corners
        send_request(ACT_STOP, 4'd15, 4'd15, 4'd15, 4'd15);
        send_request(ACT_SET_TIME, 4'd15, 4'd15, 4'd15, 4'd15);  // clamps to 23:59
        tick();                                                 // wraps to 00:00
        send_request(ACT_SET_TIME, 4'd1, 4'd15, 4'd7, 4'd12);   // clamps to 19:59
        tick();                                                 // hour tens carry
        send_request(ACT_SET_TIME, 4'd0, 4'd9, 4'd5, 4'd9);
        tick();                                                 // 10:00
        send_request(ACT_SET_ALARM, 4'd1, 4'd0, 4'd0, 4'd1);
        tick();                                                 // alarm match
        tick();                                                 // ring holds
        send_request(ACT_STOP, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_SET_ALARM, 4'd1, 4'd0, 4'd0, 4'd2);    // matches on load
        send_request(ACT_STOP, 4'd0, 4'd0, 4'd0, 4'd0);
        send_request(ACT_SET_COUNT, 4'd15, 4'd15, 4'd15, 4'd15); // clamps to 9959
        tick();
        send_request(ACT_SET_COUNT, 4'd1, 4'd0, 4'd0, 4'd0);
        tick();                                                 // borrow from top
        send_request(ACT_SET_COUNT, 4'd0, 4'd1, 4'd0, 4'd0);
        tick();
        send_request(ACT_SET_COUNT, 4'd0, 4'd0, 4'd1, 4'd0);
        tick();
        send_request(ACT_SET_COUNT, 4'd0, 4'd0, 4'd0, 4'd1);
        tick();                                                 // reaches zero
        tick();                                                 // stopped, held
        send_request(ACT_SET_COUNT, 4'd0, 4'd0, 4'd0, 4'd0);
        tick();                                                 // running at zero
        send_request(ACT_STOP, 4'd0, 4'd0, 4'd0, 4'd0);
        for (int a = ACT_STOP + 1; a < ACTION_CODES; a++)
            send_request(3'(a), 4'd15, 4'd0, 4'd15, 4'd0);      // unused codes

        // Random: mostly well-formed scenarios, some noise
        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // Set the alarm a few minutes ahead and tick up to it
                    target = $urandom_range(0, MINUTES_PER_DAY - 1);
                    lead   = $urandom_range(0, 10);
                    send_minutes(ACT_SET_TIME,
                                 (target - lead + MINUTES_PER_DAY) % MINUTES_PER_DAY);
                    send_minutes(ACT_SET_ALARM, target);
                    repeat (lead + $urandom_range(0, 3)) tick();
                    if ($urandom_range(0, 1))
                        send_request(ACT_STOP, 4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)));
                end
                3, 4, 5:
                begin
                    // Load a countdown, mostly short enough to expire
                    c3 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
                    c2 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
                    c1 = $urandom_range(0, 1) ? $urandom_range(0, 7) : 0;
                    c0 = $urandom_range(0, 15);
                    send_request(ACT_SET_COUNT, 4'(c3), 4'(c2), 4'(c1), 4'(c0));
                    total = ((c1 > 5) ? 5 : c1) * 10 + ((c0 > 9) ? 9 : c0);
                    if (c3 == 0 && c2 == 0 && $urandom_range(0, 2) != 0)
                        extra = total + $urandom_range(0, 3);
                    else
                        extra = $urandom_range(0, 12);
                    repeat (extra)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            send_request(ACT_STOP, 4'd0, 4'd0, 4'd0, 4'd0);
                        else
                            tick();
                    end
                end
                6:
                begin
                    // Approach an hour boundary, often the end of the day
                    hh = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
                    lead = $urandom_range(0, 3);
                    send_minutes(ACT_SET_TIME, hh * 60 + 59 - lead);
                    repeat (lead + 2) tick();
                end
                7, 8:
                begin
                    // Tick-heavy mix of every request kind
                    runs = $urandom_range(5, 20);
                    repeat (runs)
                    begin
                        c0 = $urandom_range(0, 15);
                        if (c0 < 11)      act = ACT_TICK;
                        else if (c0 < 12) act = ACT_SET_TIME;
                        else if (c0 < 13) act = ACT_SET_ALARM;
                        else if (c0 < 14) act = ACT_SET_COUNT;
                        else              act = ACT_STOP;
                        send_request(act, 4'($urandom_range(0, 9)),
                                     4'($urandom_range(0, 9)),
                                     4'($urandom_range(0, 9)),
                                     4'($urandom_range(0, 9)));
                    end
                end
                default:
                begin
                    // Noise: any code, any digit pattern
                    repeat ($urandom_range(1, 6))
                        send_request(3'($urandom_range(0, ACTION_CODES - 1)),
                                     4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)));
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d random requests after the directed corners, %0d results checked",
                 requests_sent, results_checked);
        $display("Results with alarm ringing: %0d, with countdown expired: %0d",
                 ring_results, expiry_results);
        if (mismatch_count == 0)
        begin
            $display("bcd_alarm_clock_countdown_top verification clean");
        end
        else
        begin
            $display("Mismatches: %0d", mismatch_count);
            $display("bcd_alarm_clock_countdown_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/bacc_pkg.sv
hdl/bacc_cell.sv
hdl/bacc_outbuf.sv
hdl/bcd_alarm_clock_countdown_top.sv
hdl/bacc_checker.sv
verif/bcd_alarm_clock_countdown_checker.sv
verif/bcd_alarm_clock_countdown_top_test.sv
